/* sv/rbs_pkg.sv */
// ----------------------------------------------------------------------------
// rbs_pkg: shared types and constants for the ray/box slab test
// Coordinate format, transaction payloads, register map and lane results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbs_pkg;

    // coordinate format (signed fixed point)
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int EPS_WIDTH   = 16;
    localparam int DIST_WIDTH  = COORD_WIDTH - 1;
    localparam int NUM_AXES    = 3;

    // largest clamped slab time
    localparam logic signed [COORD_WIDTH-1:0] T_LIMIT = {1'b0, {DIST_WIDTH{1'b1}}};

    // register map, one 32-bit word per register
    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5,
        REG_EPS   = 3'd6
    } reg_idx_t;

    // input transaction
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] origin_x;
        logic signed [COORD_WIDTH-1:0] origin_y;
        logic signed [COORD_WIDTH-1:0] origin_z;
        logic signed [COORD_WIDTH-1:0] direction_x;
        logic signed [COORD_WIDTH-1:0] direction_y;
        logic signed [COORD_WIDTH-1:0] direction_z;
    } ray_t;

    // output transaction
    typedef struct packed {
        logic                  hit;
        logic [DIST_WIDTH-1:0] entry_distance;
        logic                  distance_saturated;
    } result_t;

    // what one axis lane hands to the merge stage
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] t_min;
        logic signed [COORD_WIDTH-1:0] t_max;
        logic                          par;
        logic                          outside;
        logic                          sat;
    } lane_res_t;

endpackage

`default_nettype wire

/* sv/rbs_div.sv */
// ----------------------------------------------------------------------------
// rbs_div: pipelined fixed-point slab divider
// One quotient bit per stage, clamps overflowing quotients to T_LIMIT.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbs_div (
    input  wire logic                                   clk,
    input  wire logic [rbs_pkg::COORD_WIDTH:0]          num_mag,
    input  wire logic [rbs_pkg::COORD_WIDTH-1:0]        den_mag,
    input  wire logic                                   neg,
    output logic signed [rbs_pkg::COORD_WIDTH-1:0]      t,
    output logic                                        sat
);
    import rbs_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int QW = CW - 1;
    localparam int RW = CW + 1;
    localparam int TW = 2 * CW + 1 + FRAC_BITS;

    logic [RW-1:0] rem_reg   [0:QW];
    logic [QW-1:0] low_reg   [0:QW];
    logic [QW-1:0] quo_reg   [0:QW];
    logic [CW-1:0] den_reg   [0:QW];
    logic          neg_reg   [0:QW];
    logic          sat_reg   [0:QW];

    logic [TW-1:0] num_ext;
    logic [TW-1:0] den_ext;
    logic [CW-1:0] res;
    logic signed [CW-1:0] t_next;

    // scaled numerator and overflow check
    assign num_ext = TW'(num_mag) << FRAC_BITS;
    assign den_ext = TW'(den_mag) << QW;

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num_ext[QW +: RW];
        low_reg[0] <= num_ext[QW-1:0];
        quo_reg[0] <= '0;
        den_reg[0] <= den_mag;
        neg_reg[0] <= neg;
        sat_reg[0] <= (num_ext >= den_ext);
    end

    // one restoring step per stage
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [RW-1:0] shifted;
        logic          ge;

        assign shifted = {rem_reg[k][RW-2:0], low_reg[k][QW-1]};
        assign ge      = (shifted >= {1'b0, den_reg[k]});

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= ge ? (shifted - {1'b0, den_reg[k]}) : shifted;
            low_reg[k+1] <= {low_reg[k][QW-2:0], 1'b0};
            quo_reg[k+1] <= {quo_reg[k][QW-2:0], ge};
            den_reg[k+1] <= den_reg[k];
            neg_reg[k+1] <= neg_reg[k];
            sat_reg[k+1] <= sat_reg[k];
        end
    end

    // clamp and apply sign
    assign res    = sat_reg[QW] ? T_LIMIT : {1'b0, quo_reg[QW]};
    assign t_next = neg_reg[QW] ? -signed'(res) : signed'(res);

    always_ff @(posedge clk)
    begin
        t   <= t_next;
        sat <= sat_reg[QW];
    end

endmodule

`default_nettype wire

/* sv/rbs_lane.sv */
// ----------------------------------------------------------------------------
// rbs_lane: one axis of the slab test
// Slab distances, two dividers, parallel check and entry/exit ordering.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbs_lane (
    input  wire logic                                   clk,
    input  wire logic signed [rbs_pkg::COORD_WIDTH-1:0] org,
    input  wire logic signed [rbs_pkg::COORD_WIDTH-1:0] dir,
    input  wire logic signed [rbs_pkg::COORD_WIDTH-1:0] lo,
    input  wire logic signed [rbs_pkg::COORD_WIDTH-1:0] hi,
    input  wire logic [rbs_pkg::EPS_WIDTH-1:0]          eps,
    output rbs_pkg::lane_res_t                          res
);
    import rbs_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int DLAT  = CW + 1;

    logic signed [CW:0] diff_lo;
    logic signed [CW:0] diff_hi;
    logic [CW-1:0]      dir_mag;

    logic [CW:0]   n_lo_reg;
    logic [CW:0]   n_hi_reg;
    logic [CW-1:0] d_reg;
    logic          neg_lo_reg;
    logic          neg_hi_reg;
    logic          par_pipe   [0:DLAT];
    logic          out_pipe   [0:DLAT];

    logic signed [CW-1:0] t_lo;
    logic signed [CW-1:0] t_hi;
    logic                 sat_lo;
    logic                 sat_hi;

    // slab distances and direction magnitude
    assign diff_lo = {lo[CW-1], lo} - {org[CW-1], org};
    assign diff_hi = {hi[CW-1], hi} - {org[CW-1], org};
    assign dir_mag = dir[CW-1] ? CW'(-dir) : CW'(dir);

    always_ff @(posedge clk)
    begin
        n_lo_reg    <= diff_lo[CW] ? (CW+1)'(-diff_lo) : (CW+1)'(diff_lo);
        n_hi_reg    <= diff_hi[CW] ? (CW+1)'(-diff_hi) : (CW+1)'(diff_hi);
        d_reg       <= dir_mag;
        neg_lo_reg  <= diff_lo[CW] ^ dir[CW-1];
        neg_hi_reg  <= diff_hi[CW] ^ dir[CW-1];
        par_pipe[0] <= (dir_mag == '0) || (dir_mag < CW'(eps));
        out_pipe[0] <= (org < lo) || (org > hi);
    end

    // flags ride alongside the dividers
    for (genvar k = 0; k < DLAT; k++) begin : g_flag
        always_ff @(posedge clk)
        begin
            par_pipe[k+1] <= par_pipe[k];
            out_pipe[k+1] <= out_pipe[k];
        end
    end

    rbs_div u_div_lo (
        .clk     (clk),
        .num_mag (n_lo_reg),
        .den_mag (d_reg),
        .neg     (neg_lo_reg),
        .t       (t_lo),
        .sat     (sat_lo)
    );

    rbs_div u_div_hi (
        .clk     (clk),
        .num_mag (n_hi_reg),
        .den_mag (d_reg),
        .neg     (neg_hi_reg),
        .t       (t_hi),
        .sat     (sat_hi)
    );

    // order entry and exit
    always_ff @(posedge clk)
    begin
        res.t_min   <= (t_lo > t_hi) ? t_hi : t_lo;
        res.t_max   <= (t_lo > t_hi) ? t_lo : t_hi;
        res.par     <= par_pipe[DLAT];
        res.outside <= out_pipe[DLAT];
        res.sat     <= (sat_lo | sat_hi) & ~par_pipe[DLAT];
    end

endmodule

`default_nettype wire

/* sv/rbs_merge.sv */
// ----------------------------------------------------------------------------
// rbs_merge: combines the three axis lanes
// Folds slab intervals into [0, T_LIMIT] and forms the result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbs_merge (
    input  wire logic                                            clk,
    input  wire rbs_pkg::lane_res_t [rbs_pkg::NUM_AXES-1:0]      lanes,
    input  wire logic                                            box_ok,
    output rbs_pkg::result_t                                     result
);
    import rbs_pkg::*;

    logic signed [COORD_WIDTH-1:0] t_near;
    logic signed [COORD_WIDTH-1:0] t_far;
    logic                          miss;
    logic                          any_sat;
    logic                          hit;

    // interval fold over non-parallel axes
    always_comb
    begin
        t_near  = '0;
        t_far   = T_LIMIT;
        miss    = ~box_ok;
        any_sat = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            if (lanes[a].par) begin
                if (lanes[a].outside)
                    miss = 1'b1;
            end else begin
                if (lanes[a].t_min > t_near)
                    t_near = lanes[a].t_min;
                if (lanes[a].t_max < t_far)
                    t_far = lanes[a].t_max;
                any_sat = any_sat | lanes[a].sat;
            end
        end
        hit = ~miss && (t_near <= t_far);
    end

    always_ff @(posedge clk)
    begin
        result.hit                <= hit;
        result.entry_distance     <= hit ? t_near[DIST_WIDTH-1:0] : '0;
        result.distance_saturated <= hit & any_sat;
    end

endmodule

`default_nettype wire

/* sv/ray_box_slab_test.sv */
// ----------------------------------------------------------------------------
// ray_box_slab_test: ray versus axis-aligned box, slab method
// Box corners and the parallel threshold sit in APB registers.
// ----------------------------------------------------------------------------
// A new ray may be started in every clock cycle; busy stays low. Each ray
// produces exactly one result, marked by done, after it has passed the
// slab dividers, which resolve one quotient bit per pipeline stage; the
// three axes run in parallel lanes. Results cannot be held off and must
// be taken when done is high. Registers may be written only when no ray
// is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ray_box_slab_test (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // ray transactions
    input  wire logic             start,
    input  wire rbs_pkg::ray_t    ray,
    output logic                  busy,
    output logic                  done,
    output rbs_pkg::result_t      result,
    // configuration
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [4:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import rbs_pkg::*;

    localparam int LAT = COORD_WIDTH + 4;

    logic signed [COORD_WIDTH-1:0] box_min_reg [0:NUM_AXES-1];
    logic signed [COORD_WIDTH-1:0] box_max_reg [0:NUM_AXES-1];
    logic [EPS_WIDTH-1:0]          eps_reg;
    logic [LAT-1:0]                valid_reg;
    logic [LAT-1:0]                valid_next;

    logic                              wr_en;
    reg_idx_t                          wr_idx;
    logic                              box_ok;
    lane_res_t [NUM_AXES-1:0]          lanes;
    logic signed [COORD_WIDTH-1:0]     org [0:NUM_AXES-1];
    logic signed [COORD_WIDTH-1:0]     dir [0:NUM_AXES-1];

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign wr_idx = reg_idx_t'(paddr[4:2]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                box_min_reg[a] <= '0;
                box_max_reg[a] <= '0;
            end
            eps_reg <= EPS_WIDTH'(1);
        end else if (wr_en) begin
            unique case (wr_idx)
                REG_MIN_X: box_min_reg[0] <= pwdata;
                REG_MIN_Y: box_min_reg[1] <= pwdata;
                REG_MIN_Z: box_min_reg[2] <= pwdata;
                REG_MAX_X: box_max_reg[0] <= pwdata;
                REG_MAX_Y: box_max_reg[1] <= pwdata;
                REG_MAX_Z: box_max_reg[2] <= pwdata;
                REG_EPS:   eps_reg        <= pwdata[EPS_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (wr_idx)
            REG_MIN_X: prdata = box_min_reg[0];
            REG_MIN_Y: prdata = box_min_reg[1];
            REG_MIN_Z: prdata = box_min_reg[2];
            REG_MAX_X: prdata = box_max_reg[0];
            REG_MAX_Y: prdata = box_max_reg[1];
            REG_MAX_Z: prdata = box_max_reg[2];
            REG_EPS:   prdata = 32'(eps_reg);
            default:   prdata = '0;
        endcase
    end

    // transaction valid pipeline
    assign valid_next = {valid_reg[LAT-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign done = valid_reg[LAT-1];

    // per-axis lanes
    assign org[0] = ray.origin_x;
    assign org[1] = ray.origin_y;
    assign org[2] = ray.origin_z;
    assign dir[0] = ray.direction_x;
    assign dir[1] = ray.direction_y;
    assign dir[2] = ray.direction_z;

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        rbs_lane u_lane (
            .clk (clk),
            .org (org[a]),
            .dir (dir[a]),
            .lo  (box_min_reg[a]),
            .hi  (box_max_reg[a]),
            .eps (eps_reg),
            .res (lanes[a])
        );
    end

    assign box_ok = (box_min_reg[0] <= box_max_reg[0]) &&
                    (box_min_reg[1] <= box_max_reg[1]) &&
                    (box_min_reg[2] <= box_max_reg[2]);

    rbs_merge u_merge (
        .clk    (clk),
        .lanes  (lanes),
        .box_ok (box_ok),
        .result (result)
    );

    // a miss carries no distance and no saturation flag
    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.hit |-> result.entry_distance == '0 && !result.distance_saturated)
        else $error("miss result carries distance or saturation");

    // every result traces back to a ray started the pipeline depth earlier
    a_done_traced: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching start");

endmodule

`default_nettype wire
